// ===== rtl/core/sevt_pkg.sv =====
// Shared types and codes for the sorted event table.
// Holds entry, item and state types; no dependencies.
package sevt_pkg;

    localparam logic [2:0] OP_INSERT   = 3'd0;
    localparam logic [2:0] OP_REMOVE   = 3'd1;
    localparam logic [2:0] OP_ALTER    = 3'd2;
    localparam logic [2:0] OP_UPCOMING = 3'd3;
    localparam logic [2:0] OP_FILTER   = 3'd4;
    localparam logic [2:0] OP_CLEAR    = 3'd5;
    localparam logic [2:0] OP_FIRST    = 3'd6;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_NONE = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic [31:0] ev_start;
        logic [31:0] ev_end;
        logic [15:0] ev_id;
        logic [7:0]  ev_type;
    } entry_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] event_start;
        logic [31:0] event_end;
        logic [15:0] event_id;
        logic [7:0]  event_type;
        logic [31:0] query_time;
        logic        use_id;
        logic        use_start;
        logic        use_end;
        logic        use_type;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_start;
        logic [31:0] found_end;
        logic [15:0] found_id;
        logic [7:0]  found_type;
        logic        last;
    } out_item_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_RESP
    } state_t;

endpackage

// ===== rtl/core/sevt_if.sv =====
// Valid/ready channel interfaces for command and result items.
// Depends on sevt_pkg.
interface sevt_in_if;
    import sevt_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sevt_out_if;
    import sevt_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/sevt_mem.sv =====
// Entry store: one write port, one read port with registered read data.
// Depends on sevt_pkg.
module sevt_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  sevt_pkg::entry_t wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output sevt_pkg::entry_t rdata
);
    import sevt_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

    // the sequencer never reads and writes one entry in the same cycle
    a_no_overlap: assert property (@(posedge clk) (we && re) |-> (waddr != raddr))
        else $error("read and write hit the same entry");

endmodule

// ===== rtl/core/sorted_event_table.sv =====
// Sorted event table: a table of up to CAPACITY events kept in ascending
// start order (equal starts keep arrival order), stored in one synchronous
// memory with one write and one read port. Each command item runs to the
// end before the next is taken. Every entry visit is a read state, then a
// check and write-back state. Insert walks down from the tail moving
// entries up; remove and filter visit every entry, alter and upcoming stop
// at the first hit, first reads one entry; clear, an insert into a full
// table and any lookup on an empty table go straight to the result. Results
// leave through an output register, so a new command is taken while the
// last result still waits. Filter holds each match back one step so the
// final match can carry last; a stalled result side stalls the filter scan.
module sorted_event_table #(
    parameter int CAPACITY = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    sevt_in_if.sink          cmd,
    sevt_out_if.source       rsp
);
    import sevt_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic            found_reg, found_next;
    logic            pend_valid_reg, pend_valid_next;
    logic            out_valid_reg, out_valid_next;
    entry_t          pend_reg, pend_next;
    in_item_t        cmd_reg, cmd_next;
    logic [1:0]      resp_status_reg, resp_status_next;
    logic            resp_has_reg, resp_has_next;
    entry_t          resp_entry_reg, resp_entry_next;
    out_item_t       out_data_reg, out_data_next;

    logic            mem_we, mem_re;
    logic [IW-1:0]   mem_waddr, mem_raddr;
    entry_t          mem_wdata, rd;

    logic            can_emit, last_e, fmatch;
    logic [CW-1:0]   idx_dec;
    entry_t          new_entry, alt_entry;

    sevt_mem #(.DEPTH(CAPACITY), .AW(IW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rd)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // output slot is free or drains this cycle
    assign can_emit = !out_valid_reg || rsp.ready;
    assign idx_dec  = idx_reg - CW'(1);
    assign last_e   = ((idx_reg + CW'(1)) == count_reg);

    assign new_entry = '{ev_start: cmd_reg.event_start, ev_end: cmd_reg.event_end,
                         ev_id: cmd_reg.event_id, ev_type: cmd_reg.event_type};

    always_comb
    begin
        alt_entry = rd;
        if (cmd_reg.use_end)
        begin
            alt_entry.ev_end = cmd_reg.event_end;
        end
        if (cmd_reg.use_type)
        begin
            alt_entry.ev_type = cmd_reg.event_type;
        end
    end

    // filter keeps an entry only when every enabled test passes
    assign fmatch = (!cmd_reg.use_id || (rd.ev_id == cmd_reg.event_id))
                 && (!cmd_reg.use_start || (rd.ev_start > cmd_reg.event_start))
                 && (!cmd_reg.use_end || (rd.ev_end < cmd_reg.event_end))
                 && (!cmd_reg.use_type || (rd.ev_type == cmd_reg.event_type));

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        found_next       = found_reg;
        pend_valid_next  = pend_valid_reg;
        pend_next        = pend_reg;
        cmd_next         = cmd_reg;
        resp_status_next = resp_status_reg;
        resp_has_next    = resp_has_reg;
        resp_entry_next  = resp_entry_reg;
        out_data_next    = out_data_reg;
        out_valid_next   = rsp.ready ? 1'b0 : out_valid_reg;
        mem_we           = 1'b0;
        mem_waddr        = idx_reg[IW-1:0];
        mem_wdata        = new_entry;
        mem_re           = 1'b0;
        mem_raddr        = idx_reg[IW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    cmd_next         = cmd.data;
                    found_next       = 1'b0;
                    pend_valid_next  = 1'b0;
                    idx_next         = '0;
                    resp_has_next    = 1'b0;
                    resp_status_next = STAT_NONE;
                    case (cmd.data.op)
                        OP_INSERT:
                        begin
                            if (count_reg == FULL_COUNT)
                            begin
                                resp_status_next = STAT_FULL;
                                state_next       = S_RESP;
                            end
                            else
                            begin
                                // walk down from the tail, shifting up
                                idx_next   = count_reg;
                                state_next = S_READ;
                            end
                        end
                        OP_REMOVE, OP_ALTER, OP_UPCOMING, OP_FILTER, OP_FIRST:
                        begin
                            state_next = (count_reg == '0) ? S_RESP : S_READ;
                        end
                        OP_CLEAR:
                        begin
                            count_next       = '0;
                            resp_status_next = STAT_OK;
                            state_next       = S_RESP;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                if (cmd_reg.op == OP_INSERT)
                begin
                    if (idx_reg == '0)
                    begin
                        mem_we           = 1'b1;
                        count_next       = count_reg + CW'(1);
                        resp_status_next = STAT_OK;
                        state_next       = S_RESP;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = idx_dec[IW-1:0];
                        state_next = S_CHECK;
                    end
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                case (cmd_reg.op)
                    OP_INSERT:
                    begin
                        mem_we = 1'b1;
                        if (rd.ev_start > cmd_reg.event_start)
                        begin
                            mem_wdata  = rd;
                            idx_next   = idx_dec;
                            state_next = S_READ;
                        end
                        else
                        begin
                            count_next       = count_reg + CW'(1);
                            resp_status_next = STAT_OK;
                            state_next       = S_RESP;
                        end
                    end
                    OP_REMOVE:
                    begin
                        // after the hit, move each entry down one place
                        if (found_reg)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = idx_dec[IW-1:0];
                            mem_wdata = rd;
                        end
                        else if (rd.ev_id == cmd_reg.event_id)
                        begin
                            found_next = 1'b1;
                        end
                        if (last_e)
                        begin
                            if (found_next)
                            begin
                                count_next       = count_reg - CW'(1);
                                resp_status_next = STAT_OK;
                            end
                            state_next = S_RESP;
                        end
                        else
                        begin
                            idx_next   = idx_reg + CW'(1);
                            state_next = S_READ;
                        end
                    end
                    OP_ALTER:
                    begin
                        if (rd.ev_id == cmd_reg.event_id)
                        begin
                            mem_we           = 1'b1;
                            mem_wdata        = alt_entry;
                            resp_status_next = STAT_OK;
                            state_next       = S_RESP;
                        end
                        else if (last_e)
                        begin
                            state_next = S_RESP;
                        end
                        else
                        begin
                            idx_next   = idx_reg + CW'(1);
                            state_next = S_READ;
                        end
                    end
                    OP_UPCOMING:
                    begin
                        if (rd.ev_start > cmd_reg.query_time)
                        begin
                            resp_status_next = STAT_OK;
                            resp_has_next    = 1'b1;
                            resp_entry_next  = rd;
                            state_next       = S_RESP;
                        end
                        else if (last_e)
                        begin
                            state_next = S_RESP;
                        end
                        else
                        begin
                            idx_next   = idx_reg + CW'(1);
                            state_next = S_READ;
                        end
                    end
                    OP_FIRST:
                    begin
                        resp_status_next = STAT_OK;
                        resp_has_next    = 1'b1;
                        resp_entry_next  = rd;
                        state_next       = S_RESP;
                    end
                    OP_FILTER:
                    begin
                        // hold here while an earlier match cannot leave
                        if (!(fmatch && pend_valid_reg && !can_emit))
                        begin
                            if (fmatch && pend_valid_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_data_next  = '{status: STAT_OK,
                                                   found_start: pend_reg.ev_start,
                                                   found_end: pend_reg.ev_end,
                                                   found_id: pend_reg.ev_id,
                                                   found_type: pend_reg.ev_type,
                                                   last: 1'b0};
                            end
                            if (fmatch)
                            begin
                                pend_next       = rd;
                                pend_valid_next = 1'b1;
                            end
                            if (last_e)
                            begin
                                if (fmatch || pend_valid_reg)
                                begin
                                    resp_status_next = STAT_OK;
                                    resp_has_next    = 1'b1;
                                    resp_entry_next  = fmatch ? rd : pend_reg;
                                end
                                state_next = S_RESP;
                            end
                            else
                            begin
                                idx_next   = idx_reg + CW'(1);
                                state_next = S_READ;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end

            S_RESP:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{status: resp_status_reg,
                                       found_start: resp_has_reg ? resp_entry_reg.ev_start : '0,
                                       found_end: resp_has_reg ? resp_entry_reg.ev_end : '0,
                                       found_id: resp_has_reg ? resp_entry_reg.ev_id : '0,
                                       found_type: resp_has_reg ? resp_entry_reg.ev_type : '0,
                                       last: 1'b1};
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg        <= pend_next;
        cmd_reg         <= cmd_next;
        resp_status_reg <= resp_status_next;
        resp_has_reg    <= resp_has_next;
        resp_entry_reg  <= resp_entry_next;
        out_data_reg    <= out_data_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count beyond capacity");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("memory written with no command in progress");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && (cmd.data.op == OP_CLEAR)) |=> (count_reg == '0))
        else $error("clear left entries behind");

    a_resp_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("pending result changed before it was taken");

endmodule

// ===== verif/sevt_checker.sv =====
// Checker for the sorted event table: watches command and result channels,
// predicts each item's results and compares them. Depends on sevt_pkg, sevt_if.
`timescale 1ns / 1ps
module sevt_checker #(
    parameter int CAPACITY = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    sevt_in_if         cmd,
    sevt_out_if        rsp,
    output int         fail_count,
    output int         pending
);
    import sevt_pkg::*;

    entry_t    shadow_table[CAPACITY];
    int        shadow_count;
    out_item_t expected_results[$];

    assign pending = expected_results.size();

    function automatic out_item_t make_result(logic [1:0] st, int idx, logic lst);
        out_item_t r;
        r = '0;
        r.status = st;
        r.last = lst;
        if (idx >= 0)
        begin
            r.found_start = shadow_table[idx].ev_start;
            r.found_end   = shadow_table[idx].ev_end;
            r.found_id    = shadow_table[idx].ev_id;
            r.found_type  = shadow_table[idx].ev_type;
        end
        return r;
    endfunction

    function automatic int locate_id(logic [15:0] id);
        for (int i = 0; i < shadow_count; i++)
            if (shadow_table[i].ev_id == id)
                return i;
        return -1;
    endfunction

    // Append one result at the tail of the expected queue.
    task automatic queue_result(out_item_t r);
        expected_results = {expected_results, r};
    endtask

    // Apply one command to the shadow table and queue its results.
    task automatic predict_command(in_item_t c);
        int pos;
        int idx;
        int hits;
        out_item_t r;
        case (c.op)
            OP_INSERT:
            begin
                if (shadow_count >= CAPACITY)
                    queue_result(make_result(STAT_FULL, -1, 1'b1));
                else
                begin
                    pos = 0;
                    while (pos < shadow_count && shadow_table[pos].ev_start <= c.event_start)
                        pos++;
                    for (int i = shadow_count; i > pos; i--)
                        shadow_table[i] = shadow_table[i - 1];
                    shadow_table[pos] = '{c.event_start, c.event_end, c.event_id,
                                          c.event_type};
                    shadow_count++;
                    queue_result(make_result(STAT_OK, -1, 1'b1));
                end
            end
            OP_REMOVE:
            begin
                idx = locate_id(c.event_id);
                if (idx < 0)
                    queue_result(make_result(STAT_NONE, -1, 1'b1));
                else
                begin
                    for (int i = idx; i + 1 < shadow_count; i++)
                        shadow_table[i] = shadow_table[i + 1];
                    shadow_count--;
                    queue_result(make_result(STAT_OK, -1, 1'b1));
                end
            end
            OP_ALTER:
            begin
                idx = locate_id(c.event_id);
                if (idx < 0)
                    queue_result(make_result(STAT_NONE, -1, 1'b1));
                else
                begin
                    if (c.use_end)
                        shadow_table[idx].ev_end = c.event_end;
                    if (c.use_type)
                        shadow_table[idx].ev_type = c.event_type;
                    queue_result(make_result(STAT_OK, -1, 1'b1));
                end
            end
            OP_UPCOMING:
            begin
                idx = -1;
                for (int i = 0; i < shadow_count && idx < 0; i++)
                    if (shadow_table[i].ev_start > c.query_time)
                        idx = i;
                queue_result(make_result(idx < 0 ? STAT_NONE : STAT_OK, idx, 1'b1));
            end
            OP_FILTER:
            begin
                hits = 0;
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (c.use_id && shadow_table[i].ev_id != c.event_id) continue;
                    if (c.use_start && !(shadow_table[i].ev_start > c.event_start)) continue;
                    if (c.use_end && !(shadow_table[i].ev_end < c.event_end)) continue;
                    if (c.use_type && shadow_table[i].ev_type != c.event_type) continue;
                    queue_result(make_result(STAT_OK, i, 1'b0));
                    hits++;
                end
                if (hits == 0)
                    queue_result(make_result(STAT_NONE, -1, 1'b1));
                else
                begin
                    r = expected_results.pop_back();
                    r.last = 1'b1;
                    queue_result(r);
                end
            end
            OP_CLEAR:
            begin
                shadow_count = 0;
                queue_result(make_result(STAT_OK, -1, 1'b1));
            end
            OP_FIRST:
                queue_result(make_result(shadow_count == 0 ? STAT_NONE : STAT_OK,
                                         shadow_count == 0 ? -1 : 0, 1'b1));
            default:
                queue_result(make_result(STAT_NONE, -1, 1'b1));
        endcase
    endtask

    task automatic compare_result(out_item_t got);
        out_item_t want;
        if (expected_results.size() == 0)
        begin
            $error("unexpected result item status=%0d", got.status);
            fail_count++;
            return;
        end
        want = expected_results.pop_front();
        if (got.status !== want.status)
        begin
            $error("status expected %0d actual %0d", want.status, got.status);
            fail_count++;
        end
        if (got.found_start !== want.found_start)
        begin
            $error("found_start expected %0h actual %0h", want.found_start, got.found_start);
            fail_count++;
        end
        if (got.found_end !== want.found_end)
        begin
            $error("found_end expected %0h actual %0h", want.found_end, got.found_end);
            fail_count++;
        end
        if (got.found_id !== want.found_id)
        begin
            $error("found_id expected %0h actual %0h", want.found_id, got.found_id);
            fail_count++;
        end
        if (got.found_type !== want.found_type)
        begin
            $error("found_type expected %0h actual %0h", want.found_type, got.found_type);
            fail_count++;
        end
        if (got.last !== want.last)
        begin
            $error("last expected %0b actual %0b", want.last, got.last);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        shadow_count = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // Check results first: a command taken in the same cycle is
            // queued behind everything already expected.
            if (rsp.valid && rsp.ready)
                compare_result(rsp.data);
            if (cmd.valid && cmd.ready)
                predict_command(cmd.data);
        end
    end
endmodule

// ===== verif/tb_sorted_event_table.sv =====
// Top of the sorted event table testbench: clock, reset, command stimulus,
// result back-pressure and verdict. Depends on sevt_pkg, sevt_if, sevt_checker.
`timescale 1ns / 1ps
module tb_sorted_event_table;
    import sevt_pkg::*;

    localparam int CAPACITY = 16;
    localparam int RANDOM_ITEMS = 310;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    bit   hold_results;   // long receiver hold-off requested by stimulus
    bit   drain_mode;     // receiver stays ready (final drain)

    sevt_in_if  cmd ();
    sevt_out_if rsp ();

    sorted_event_table #(.CAPACITY(CAPACITY)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    sevt_checker #(.CAPACITY(CAPACITY)) scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Small pools of ids, starts and types so that lookups hit, starts
    // collide and filters match; a few draws go to the full range.
    logic [15:0] live_ids[$];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Mostly short gaps, now and then a long one, sometimes none.
    function automatic int gap_length();
        int p;
        p = $urandom_range(99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic logic [31:0] pick_time();
        case ($urandom_range(5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(40);
        endcase
    endfunction

    function automatic logic [15:0] pick_id();
        if (live_ids.size() > 0 && $urandom_range(3) != 0)
            return live_ids[$urandom_range(live_ids.size() - 1)];
        if ($urandom_range(4) == 0)
            return 16'($urandom);
        return 16'($urandom_range(12));
    endfunction

    function automatic in_item_t random_command();
        in_item_t c;
        int p;
        c = '0;
        c.event_start = pick_time();
        c.event_end   = pick_time();
        c.query_time  = pick_time();
        c.event_id    = pick_id();
        c.event_type  = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
        {c.use_id, c.use_start, c.use_end, c.use_type} = 4'($urandom);
        // Weight toward inserts so the table spends time partly and fully filled.
        p = $urandom_range(99);
        if (p < 38)      c.op = OP_INSERT;
        else if (p < 50) c.op = OP_REMOVE;
        else if (p < 62) c.op = OP_ALTER;
        else if (p < 72) c.op = OP_UPCOMING;
        else if (p < 88) c.op = OP_FILTER;
        else if (p < 91) c.op = OP_CLEAR;
        else if (p < 98) c.op = OP_FIRST;
        else             c.op = 3'd7;
        return c;
    endfunction

    // Offer one item at the falling edge and hold it until accepted.
    task automatic send_command(in_item_t c);
        cmd.valid <= 1'b1;
        cmd.data  <= c;
        if (c.op == OP_INSERT)
            live_ids = {live_ids, c.event_id};
        if (c.op == OP_CLEAR)
            live_ids.delete();
        do @(posedge clk); while (!cmd.ready);
        @(negedge clk);
    endtask

    task automatic send_with_gap(in_item_t c);
        int g;
        send_command(c);
        g = gap_length();
        if (g > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    function automatic in_item_t make_command(logic [2:0] op, logic [31:0] st,
                                              logic [31:0] en, logic [15:0] id,
                                              logic [7:0] ty, logic [31:0] qt,
                                              logic [3:0] flags);
        in_item_t c;
        c.op = op;
        c.event_start = st;
        c.event_end = en;
        c.event_id = id;
        c.event_type = ty;
        c.query_time = qt;
        {c.use_id, c.use_start, c.use_end, c.use_type} = flags;
        return c;
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        int g;
        bit held;
        held = 1'b0;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_results && !held)
            begin
                held = 1'b1;
                rsp.ready <= 1'b0;
                repeat (300) @(negedge clk);
            end
            else if (drain_mode)
                rsp.ready <= 1'b1;
            else
            begin
                g = gap_length();
                if (g == 0 || $urandom_range(2) == 0)
                    rsp.ready <= 1'b1;
                else
                begin
                    rsp.ready <= 1'b0;
                    repeat (g - 1) @(negedge clk);
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int wait_cycles;
        rst_n = 1'b0;
        hold_results = 1'b0;
        drain_mode = 1'b0;
        cmd.valid = 1'b0;
        cmd.data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty-table cases, extremes, equal starts, every op.
        send_command(make_command(OP_FIRST, 0, 0, 0, 0, 0, 4'h0));
        send_command(make_command(OP_FILTER, 0, 0, 0, 0, 0, 4'h0));
        send_command(make_command(OP_UPCOMING, 0, 0, 0, 0, 0, 4'h0));
        send_command(make_command(OP_REMOVE, 0, 0, 16'hFFFF, 0, 0, 4'h0));
        send_command(make_command(OP_ALTER, 0, 0, 16'h1, 0, 0, 4'hF));
        send_command(make_command(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  16'hFFFF, 8'hFF, 0, 4'hF));
        send_command(make_command(OP_INSERT, 32'h0, 32'h0, 16'h0, 8'h0, 0, 4'h0));
        send_command(make_command(OP_INSERT, 32'd5, 32'd9, 16'd7, 8'd1, 0, 4'h0));
        send_command(make_command(OP_INSERT, 32'd5, 32'd3, 16'd7, 8'd2, 0, 4'h0));
        send_command(make_command(OP_UPCOMING, 0, 0, 0, 0, 32'd4, 4'h0));
        send_command(make_command(OP_UPCOMING, 0, 0, 0, 0, 32'hFFFF_FFFF, 4'h0));
        send_command(make_command(OP_ALTER, 0, 32'd100, 16'd7, 8'd9, 0, 4'h0));
        send_command(make_command(OP_ALTER, 0, 32'd100, 16'd7, 8'd9, 0, 4'h2));
        send_command(make_command(OP_ALTER, 0, 32'd100, 16'd7, 8'd9, 0, 4'h1));
        send_command(make_command(OP_FILTER, 0, 0, 0, 0, 0, 4'h0));
        send_command(make_command(OP_FILTER, 32'd0, 32'd50, 16'd7, 8'd2, 0, 4'hF));
        send_command(make_command(OP_FILTER, 32'hFFFF_FFFF, 0, 0, 0, 0, 4'h4));
        send_command(make_command(OP_REMOVE, 0, 0, 16'd7, 0, 0, 4'h0));
        send_command(make_command(OP_FIRST, 0, 0, 0, 0, 0, 4'h0));
        send_command(make_command(3'd7, 0, 0, 0, 0, 0, 4'hF));
        for (int i = 0; i < CAPACITY; i++)
            send_command(make_command(OP_INSERT, $urandom_range(9), $urandom,
                                      16'(i), 8'(i), 0, 4'h0));
        send_command(make_command(OP_INSERT, 32'd3, 0, 16'd99, 0, 0, 4'h0));
        send_command(make_command(OP_FILTER, 0, 0, 0, 0, 0, 4'h0));
        send_command(make_command(OP_CLEAR, 0, 0, 0, 0, 0, 4'h0));

        // Long receiver hold-off while commands keep coming: fills the
        // output path and stalls the command side.
        hold_results = 1'b1;
        for (int i = 0; i < 30; i++)
            send_command(random_command());
        cmd.valid <= 1'b0;

        // Pause until every expected result has arrived.
        while (pending != 0) @(negedge clk);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            send_with_gap(random_command());
            if (i == RANDOM_ITEMS / 2)
            begin
                cmd.valid <= 1'b0;
                while (pending != 0) @(negedge clk);
            end
        end
        cmd.valid <= 1'b0;

        drain_mode = 1'b1;
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 200000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (60) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/sevt_pkg.sv
rtl/core/sevt_if.sv
rtl/core/sevt_mem.sv
rtl/core/sorted_event_table.sv
verif/sevt_checker.sv
verif/tb_sorted_event_table.sv
